FILE: rtl/afrc_pkg.sv
package afrc_pkg;

    localparam int FRAME_LIMIT   = 192;
    localparam int PAYLOAD_LIMIT = 256;
    localparam int CNT_W         = $clog2(FRAME_LIMIT - 1);
    localparam int OVF_AT        = FRAME_LIMIT - 2;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_F     = 8'h46;

    localparam logic [2:0] HEX_DIGITS = 3'd4;
    localparam logic [2:0] HEX_SAT    = 3'd5;

    localparam logic [2:0] FLAG_NUL    = 3'b001;
    localparam logic [2:0] FLAG_EDGE   = 3'b010;
    localparam logic [2:0] FLAG_DOUBLE = 3'b100;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_CRC    = 2'd1;
    localparam logic [1:0] ST_PARSE  = 2'd2;
    localparam logic [1:0] ST_OVF    = 2'd3;

    typedef struct packed {
        logic [15:0]      crc_run;
        logic [15:0]      crc_star;
        logic             star_seen;
        logic [CNT_W-1:0] star_pos;
        logic [2:0]       hex_cnt;
        logic             hex_ok;
        logic [15:0]      rx_crc;
        logic [7:0]       prev;
        logic [2:0]       flags;
        logic [2:0]       flags_star;
    } an_state_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  len;
        logic [15:0] crc;
    } result_t;

    localparam an_state_t AN_CLEAR = '{
        crc_run:    CRC_INIT,
        crc_star:   CRC_INIT,
        star_seen:  1'b0,
        star_pos:   '0,
        hex_cnt:    3'd0,
        hex_ok:     1'b1,
        rx_crc:     16'd0,
        prev:       8'd0,
        flags:      3'd0,
        flags_star: 3'd0
    };

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] c);
        logic [15:0] r;
        r = crc ^ {c, 8'd0};
        for (int k = 0; k < 8; k++)
        begin
            if (r[15])
                r = {r[14:0], 1'b0} ^ CRC_POLY;
            else
                r = {r[14:0], 1'b0};
        end
        return r;
    endfunction

    function automatic an_state_t analyze(input an_state_t s, input logic [7:0] c,
                                          input logic [CNT_W-1:0] idx);
        an_state_t  o;
        logic [3:0] v;
        o = s;
        v = 4'd0;
        if (c == CH_STAR)
        begin
            o.crc_star   = s.crc_run;
            o.star_seen  = 1'b1;
            o.star_pos   = idx;
            o.hex_cnt    = 3'd0;
            o.hex_ok     = 1'b1;
            o.rx_crc     = 16'd0;
            o.flags_star = s.flags;
            if (idx != '0 && s.prev == CH_COMMA)
                o.flags_star = s.flags | FLAG_EDGE;
        end
        else if (s.star_seen)
        begin
            if (s.hex_cnt < HEX_DIGITS)
            begin
                if (c inside {[CH_0:CH_9]})
                    v = c[3:0];
                else if (c inside {[CH_A:CH_F]})
                    v = 4'(c - CH_A + 8'd10);
                else
                    o.hex_ok = 1'b0;
                o.rx_crc = {s.rx_crc[11:0], v};
            end
            if (s.hex_cnt < HEX_SAT)
                o.hex_cnt = s.hex_cnt + 3'd1;
        end
        if (c == CH_NUL)
            o.flags = o.flags | FLAG_NUL;
        if (c == CH_COMMA)
        begin
            if (idx == '0)
                o.flags = o.flags | FLAG_EDGE;
            else if (s.prev == CH_COMMA)
                o.flags = o.flags | FLAG_DOUBLE;
        end
        o.crc_run = crc_byte(s.crc_run, c);
        o.prev    = c;
        return o;
    endfunction

endpackage

FILE: rtl/afrc_in_stage.sv
module afrc_in_stage
    import afrc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       drain,
    output logic       s1_valid,
    output logic [7:0] s1_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       take;

    assign in_stall = valid_reg & ~drain;
    assign take     = in_valid & ~in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
            valid_next = 1'b1;
        else if (drain)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            byte_reg <= rx_byte;
    end

    assign s1_valid = valid_reg;
    assign s1_byte  = byte_reg;

endmodule

FILE: rtl/afrc_deframer.sv
module afrc_deframer
    import afrc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] c,
    output logic       res_valid,
    output result_t    res
);

    logic             inside_reg, inside_next;
    logic             disc_reg, disc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             hcr_reg, hcr_next;
    an_state_t        an_reg, an_next;
    an_state_t        an_tmp;
    logic [1:0]       judge;

    always_comb
    begin
        if (!an_reg.star_seen || an_reg.star_pos == '0)
            judge = ST_PARSE;
        else if (an_reg.hex_cnt != HEX_DIGITS || !an_reg.hex_ok ||
                 an_reg.rx_crc != an_reg.crc_star)
            judge = ST_CRC;
        else if (32'(an_reg.star_pos) >= PAYLOAD_LIMIT)
            judge = ST_PARSE;
        else if (an_reg.flags_star != 3'd0)
            judge = ST_PARSE;
        else
            judge = ST_OK;
    end

    always_comb
    begin
        inside_next = inside_reg;
        disc_next   = disc_reg;
        cnt_next    = cnt_reg;
        hcr_next    = hcr_reg;
        an_next     = an_reg;
        an_tmp      = an_reg;
        res_valid   = 1'b0;
        res.status  = ST_OK;
        res.len     = 8'(an_reg.star_pos);
        res.crc     = an_reg.crc_star;
        if (fire)
        begin
            if (disc_reg)
            begin
                if (c == CH_LF)
                begin
                    disc_next   = 1'b0;
                    inside_next = 1'b0;
                    cnt_next    = '0;
                    hcr_next    = 1'b0;
                    an_next     = AN_CLEAR;
                end
            end
            else if (c == CH_LF)
            begin
                res_valid   = inside_reg && cnt_reg != '0;
                res.status  = judge;
                inside_next = 1'b0;
                cnt_next    = '0;
                hcr_next    = 1'b0;
                an_next     = AN_CLEAR;
            end
            else if (c == CH_AT)
            begin
                inside_next = 1'b1;
                cnt_next    = '0;
                hcr_next    = 1'b0;
                an_next     = AN_CLEAR;
            end
            else if (inside_reg)
            begin
                if (cnt_reg < CNT_W'(OVF_AT))
                begin
                    if (hcr_reg)
                        an_tmp = analyze(an_reg, CH_CR, cnt_reg - CNT_W'(1));
                    if (c == CH_CR)
                    begin
                        hcr_next = 1'b1;
                        an_next  = an_tmp;
                    end
                    else
                    begin
                        hcr_next = 1'b0;
                        an_next  = analyze(an_tmp, c, cnt_reg);
                    end
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                else
                begin
                    res_valid   = 1'b1;
                    res.status  = ST_OVF;
                    res.len     = 8'd0;
                    res.crc     = 16'd0;
                    disc_next   = 1'b1;
                    inside_next = 1'b0;
                    cnt_next    = '0;
                    hcr_next    = 1'b0;
                    an_next     = AN_CLEAR;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg <= 1'b0;
            disc_reg   <= 1'b0;
            cnt_reg    <= '0;
            hcr_reg    <= 1'b0;
            an_reg     <= AN_CLEAR;
        end
        else
        begin
            inside_reg <= inside_next;
            disc_reg   <= disc_next;
            cnt_reg    <= cnt_next;
            hcr_reg    <= hcr_next;
            an_reg     <= an_next;
        end
    end

    a_disc_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(disc_reg && inside_reg))
        else $error("discarding while inside a frame");
    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(OVF_AT))
        else $error("byte count past frame limit");
    a_hcr_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        hcr_reg |-> (cnt_reg != '0 && inside_reg))
        else $error("held CR without a counted byte");
    a_hex_sat: assert property (@(posedge clk) disable iff (!rst_n)
        an_reg.hex_cnt <= HEX_SAT)
        else $error("hex digit count beyond saturation");
    a_ovf_disc: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.status == ST_OVF) |=> disc_reg)
        else $error("overflow did not start discarding");

endmodule

FILE: rtl/afrc_out_stage.sv
module afrc_out_stage
    import afrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        res_valid,
    input  result_t     res,
    output logic        drain,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  frame_status,
    output logic [7:0]  payload_length,
    output logic [15:0] computed_crc
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign drain = ~valid_reg | ~out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_valid)
            valid_next = 1'b1;
        else if (!out_stall)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
            res_reg <= res;
    end

    assign out_valid      = valid_reg;
    assign frame_status   = res_reg.status;
    assign payload_length = res_reg.len;
    assign computed_crc   = res_reg.crc;

endmodule

FILE: rtl/ascii_frame_receiver_crc16_top.sv
// A byte taken into the input register is judged by the deframer as it leaves that register;
// a frame's result is then written into the output register, which drives out_valid.
// Throughput: one byte per cycle unless the output stalls; CRC over a byte (two with a held CR)
// is one XOR network. A stalled output stalls the input register and so the input channel.
// Reset (rst_n low, asynchronous): no frame open, not discarding, both stages empty.
module ascii_frame_receiver_crc16_top
    import afrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  frame_status,
    output logic [7:0]  payload_length,
    output logic [15:0] computed_crc
);

    logic       drain;
    logic       s1_valid;
    logic [7:0] s1_byte;
    logic       res_valid;
    result_t    res;

    afrc_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .drain    (drain),
        .s1_valid (s1_valid),
        .s1_byte  (s1_byte)
    );

    afrc_deframer u_dfr (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (s1_valid & drain),
        .c         (s1_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    afrc_out_stage u_out (
        .clk            (clk),
        .rst_n          (rst_n),
        .res_valid      (res_valid),
        .res            (res),
        .drain          (drain),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .frame_status   (frame_status),
        .payload_length (payload_length),
        .computed_crc   (computed_crc)
    );

endmodule
